// ===== rtl/brbp_pkg.sv =====
// shared types and constants for the byte ring buffer packer
package brbp_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 9;
	localparam int WORD_W = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [1:0] WC_ONE = 2'd0;
	localparam logic [1:0] WC_TWO = 2'd1;

	localparam logic [1:0] IDX_ONE  = 2'd0;
	localparam logic [1:0] IDX_TWO  = 2'd1;
	localparam logic [1:0] IDX_FOUR = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_XFER,
		ST_DRAIN,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic              op;
		logic [1:0]        width_code;
		logic              big_endian;
		logic [WORD_W-1:0] value;
	} item_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic [POS_W-1:0]  bytes_readable;
		logic [POS_W-1:0]  bytes_free;
	} result_word_t;

endpackage

// ===== rtl/brbp_ram.sv =====
// generic single-port ram with registered read
module brbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/brbp_pos_unit.sv =====
// shared position wrap and increment unit
module brbp_pos_unit
	import brbp_pkg::*;
#(
	parameter int ADDR_W = 8
) (
	input  logic [POS_W-1:0]  pos,
	input  logic [POS_W-1:0]  cap,
	output logic [ADDR_W-1:0] addr,
	output logic [POS_W-1:0]  pos_next
);

	logic [POS_W-1:0]        wrapped;
	logic [ADDR_W+POS_W-1:0] addr_ext;

	assign wrapped  = (pos >= cap) ? '0 : pos;
	assign pos_next = wrapped + POS_W'(1);
	assign addr_ext = {{ADDR_W{1'b0}}, wrapped};
	assign addr     = addr_ext[ADDR_W-1:0];

endmodule

// ===== rtl/byte_ring_buffer_packer_core.sv =====
// top level of the byte ring buffer packer: sequencer, positions and result register
//
// A byte-wide circular store with separate read and write positions.
// item channel (item_valid / item_stall / item): an item writes 1, 2 or 4
// bytes of value, least or most significant first, or reads 1, 2 or 4 bytes
// and assembles them least significant first. item_stall is high while an
// item is in progress; one item is handled at a time.
// result channel (result_valid / result_stall / result): one word per item
// with the read value and the readable and free byte counts after the item.
// The byte store is accessed one byte per cycle through its single port:
// an item steps through XFER, then DRAIN on reads, then PUT, and the result
// word is registered in PUT once the result register is free.
// A held result register decouples the two sides: a new item is taken while
// a result waits; if the receiver still stalls when the next result is ready,
// the sequencer holds in its final state until the register frees up.
// capacity_we / capacity_wdata set the capacity (0 acts as 1, above DEPTH
// acts as DEPTH) and put both positions back to zero; write it only when idle.
// After reset the capacity is DEPTH (at most 511), both positions are zero
// and the store contents are unknown until written.
module byte_ring_buffer_packer_core
	import brbp_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_word_t       item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_word_t     result,
	input  logic             capacity_we,
	input  logic [POS_W-1:0] capacity_wdata
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CAP_MAX_I = (DEPTH > 511) ? 511 : DEPTH;
	localparam logic [16:0] DEPTH_L = 17'(DEPTH);
	localparam logic [POS_W-1:0] CAP_MAX = POS_W'(CAP_MAX_I);

	state_t             state_q, state_d;
	logic               op_q;
	logic               be_q;
	logic [1:0]         last_q;
	logic [1:0]         cnt_q;
	logic [1:0]         cap_idx_q;
	logic               rd_pend_q;
	logic [WORD_W-1:0]  value_q;
	logic [WORD_W-1:0]  acc_q;
	logic [POS_W-1:0]   cap_q;
	logic [POS_W-1:0]   wr_pos_q;
	logic [POS_W-1:0]   rd_pos_q;
	logic               out_valid_q;
	result_word_t       out_q;

	logic               accept;
	logic               out_free;
	logic               mem_we;
	logic               step;
	logic               load_out;
	logic [1:0]         bidx;
	logic [BYTE_W-1:0]  wbyte;
	logic [BYTE_W-1:0]  rbyte;
	logic [POS_W-1:0]   pos_sel;
	logic [POS_W-1:0]   pos_next;
	logic [ADDR_W-1:0]  mem_addr;
	logic [POS_W-1:0]   readable;
	logic [POS_W-1:0]   cap_new;
	logic [1:0]         last_new;

	assign accept   = item_valid && !item_stall;
	assign out_free = !out_valid_q || !result_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_XFER;
				end
			end
			ST_XFER: begin
				if (cnt_q == last_q) begin
					state_d = (op_q == OP_READ) ? ST_DRAIN : ST_PUT;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PUT;
			end
			ST_PUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall = 1'b1;
		step       = 1'b0;
		mem_we     = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
			end
			ST_XFER: begin
				step   = 1'b1;
				mem_we = (op_q == OP_WRITE);
			end
			ST_DRAIN: begin
			end
			ST_PUT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	assign pos_sel = (op_q == OP_READ) ? rd_pos_q : wr_pos_q;

	brbp_pos_unit #(
		.ADDR_W(ADDR_W)
	) u_pos (
		.pos     (pos_sel),
		.cap     (cap_q),
		.addr    (mem_addr),
		.pos_next(pos_next)
	);

	assign bidx = be_q ? (last_q - cnt_q) : cnt_q;

	always_comb begin
		unique case (bidx)
			2'd0:    wbyte = value_q[7:0];
			2'd1:    wbyte = value_q[15:8];
			2'd2:    wbyte = value_q[23:16];
			default: wbyte = value_q[31:24];
		endcase
	end

	brbp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(wbyte),
		.rdata(rbyte)
	);

	assign readable = (wr_pos_q >= rd_pos_q) ? (wr_pos_q - rd_pos_q)
	                                         : (cap_q - (rd_pos_q - wr_pos_q));

	always_comb begin
		if (capacity_wdata == '0) begin
			cap_new = POS_W'(1);
		end else if (17'(capacity_wdata) > DEPTH_L) begin
			cap_new = CAP_MAX;
		end else begin
			cap_new = capacity_wdata;
		end
	end

	always_comb begin
		unique case (item.width_code)
			WC_ONE:  last_new = IDX_ONE;
			WC_TWO:  last_new = IDX_TWO;
			default: last_new = IDX_FOUR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_MAX;
			wr_pos_q    <= '0;
			rd_pos_q    <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			cap_idx_q   <= '0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= step && (op_q == OP_READ);
			if (capacity_we) begin
				cap_q    <= cap_new;
				wr_pos_q <= '0;
				rd_pos_q <= '0;
			end else if (step) begin
				if (op_q == OP_READ) begin
					rd_pos_q <= pos_next;
				end else begin
					wr_pos_q <= pos_next;
				end
			end
			if (accept) begin
				cnt_q     <= '0;
				cap_idx_q <= '0;
			end else begin
				if (step) begin
					cnt_q <= cnt_q + 2'd1;
				end
				if (rd_pend_q) begin
					cap_idx_q <= cap_idx_q + 2'd1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= item.op;
			be_q    <= item.big_endian;
			last_q  <= last_new;
			value_q <= item.value;
			acc_q   <= '0;
		end else if (rd_pend_q) begin
			unique case (cap_idx_q)
				2'd0:    acc_q[7:0]   <= rbyte;
				2'd1:    acc_q[15:8]  <= rbyte;
				2'd2:    acc_q[23:16] <= rbyte;
				default: acc_q[31:24] <= rbyte;
			endcase
		end
		if (load_out) begin
			out_q.read_value     <= acc_q;
			out_q.bytes_readable <= readable;
			out_q.bytes_free     <= cap_q - readable;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> item_stall)
		else $error("item taken while sequencer busy");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_pos_q <= cap_q) && (rd_pos_q <= cap_q))
		else $error("position beyond capacity");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q != '0) && (cap_q <= CAP_MAX))
		else $error("capacity out of range");

	a_result_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_PUT))
		else $error("result word loaded outside final state");
`endif

endmodule
